### rtl/radix_digit_converter_defines.svh
// assertion macros for the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rdc_pkg.sv
// shared types and constants for the radix digit converter
package rdc_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int COUNT_W     = $clog2(NUMBER_BITS + 1);
  localparam int INDEX_W     = $clog2(NUMBER_BITS);
  localparam int DIGIT_W     = 3;
  localparam int BASE_W      = 3;
  localparam int BUFSZ_W     = 8;
  localparam int CHAR_W      = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BASE_W-1:0] BASE_MIN = 3'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 3'd5;
  localparam logic [BASE_W-1:0] BASE_2   = 3'd2;
  localparam logic [BASE_W-1:0] BASE_3   = 3'd3;
  localparam logic [BASE_W-1:0] BASE_4   = 3'd4;
  localparam logic [BASE_W-1:0] BASE_5   = 3'd5;

  // reciprocal constants, exact for every 32-bit dividend
  localparam logic [NUMBER_BITS-1:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam logic [NUMBER_BITS-1:0] RECIP_5 = 32'hCCCC_CCCD;
  localparam int SHIFT_3 = 33;
  localparam int SHIFT_5 = 34;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MAX  = 6'd52;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_BASE = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic [BASE_W-1:0]      base;
    logic [BUFSZ_W-1:0]     buffer_size;
    logic                   bad_base;
  } cmd_t;

endpackage

### rtl/rdc_front.sv
// front end: accepts requests, checks the base and queues them for the back end
module rdc_front import rdc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] number_i,
  input  logic [BASE_W-1:0]      base_i,
  input  logic [BUFSZ_W-1:0]     buffer_size_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output cmd_t                   cmd_o
);

  cmd_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0] fill_q, fill_d;
  logic               push, pop;
  cmd_t               cmd_in;

  always_comb begin
    cmd_in.number      = number_i;
    cmd_in.base        = base_i;
    cmd_in.buffer_size = buffer_size_i;
    cmd_in.bad_base    = (base_i < BASE_MIN) || (base_i > BASE_MAX);
  end

  assign in_ready_o  = (fill_q != QFILL_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + QFILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QFILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/rdc_back.sv
// back end: digit extraction, digit store and result register
module rdc_back import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               has_digit_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_REPORT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [BASE_W-1:0]      base_q, base_d;
  logic [BUFSZ_W-1:0]     bufsz_q, bufsz_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [INDEX_W-1:0]     idx_q, idx_d;
  status_e                err_q, err_d;
  logic [DIGIT_W-1:0]     store_q [NUMBER_BITS];
  logic [DIGIT_W-1:0]     store_rd_q;

  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   has_q, has_d;
  status_e                stat_q, stat_d;
  logic                   last_q, last_d;

  logic [2*NUMBER_BITS-1:0] prod;
  logic [NUMBER_BITS-1:0]   quo;
  logic [DIGIT_W-1:0]       digit;
  logic [COUNT_W-1:0]       next_count;
  logic                     out_free;
  logic                     store_we;

  assign out_free = !out_valid_q || out_ready_i;

  // one multiplier, constant picked by base
  assign prod = (2*NUMBER_BITS)'(rem_q) *
                (2*NUMBER_BITS)'((base_q == BASE_5) ? RECIP_5 : RECIP_3);

  always_comb begin
    case (base_q)
      BASE_2:  quo = rem_q >> 1;
      BASE_4:  quo = rem_q >> 2;
      BASE_3:  quo = NUMBER_BITS'(prod >> SHIFT_3);
      BASE_5:  quo = NUMBER_BITS'(prod >> SHIFT_5);
      default: quo = rem_q >> 1;
    endcase
  end

  assign digit      = DIGIT_W'(rem_q[DIGIT_W-1:0] - DIGIT_W'(quo[DIGIT_W-1:0] * base_q));
  assign next_count = count_q + COUNT_W'(1);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    base_d      = base_q;
    bufsz_d     = bufsz_q;
    count_d     = count_q;
    idx_d       = idx_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    has_d       = has_q;
    stat_d      = stat_q;
    last_d      = last_q;
    cmd_ready_o = 1'b0;
    store_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          rem_d   = cmd_i.number;
          base_d  = cmd_i.base;
          bufsz_d = cmd_i.buffer_size;
          count_d = '0;
          err_d   = STATUS_BAD_BASE;
          state_d = cmd_i.bad_base ? ST_REPORT : ST_DIV;
        end
      end
      ST_DIV: begin
        store_we = 1'b1;
        rem_d    = quo;
        count_d  = next_count;
        if (quo == '0) begin
          idx_d = count_q[INDEX_W-1:0];
          if ((BUFSZ_W'(next_count) + BUFSZ_W'(1)) > bufsz_q) begin
            err_d   = STATUS_OVERFLOW;
            state_d = ST_REPORT;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = ASCII_ZERO + CHAR_W'(store_rd_q);
          has_d       = 1'b1;
          stat_d      = STATUS_OK;
          last_d      = (idx_q == '0);
          idx_d       = idx_q - INDEX_W'(1);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = '0;
          has_d       = 1'b0;
          stat_d      = err_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    bufsz_q <= bufsz_d;
    idx_q   <= idx_d;
    err_q   <= err_d;
    char_q  <= char_d;
    has_q   <= has_d;
    stat_q  <= stat_d;
    last_q  <= last_d;
    if (store_we) begin
      store_q[count_q[INDEX_W-1:0]] <= digit;
    end
    // read ahead at the next index, the digit being written passes straight through
    if (store_we && (idx_d == count_q[INDEX_W-1:0])) begin
      store_rd_q <= digit;
    end else begin
      store_rd_q <= store_q[idx_d];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign has_digit_o  = has_q;
  assign status_o     = stat_q;
  assign last_o       = last_q;

endmodule

### rtl/radix_digit_converter.sv
// top level of the radix digit converter
// Converts a 32-bit unsigned number to ASCII digits in base 2 to 5, most
// significant first, one digit per output transfer, the last one flagged.
// Zero gives the single digit '0'. A base outside 2..5 gives one result
// with status invalid base; a digit string that does not fit buffer_size
// with its terminator gives one result with status buffer overflow. A
// two-entry request queue lets new requests be taken while a conversion
// runs. The back end handles one conversion at a time: it pops a request,
// divides it down into the digit store, one digit per divide step (a
// shift for base 2 and 4, a reciprocal multiply for base 3 and 5), then
// sends the digits out of the digit store, most significant first.
module radix_digit_converter import rdc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] number_i,
  input  logic [BASE_W-1:0]      base_i,
  input  logic [BUFSZ_W-1:0]     buffer_size_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   has_digit_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  rdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .number_i      (number_i),
    .base_i        (base_i),
    .buffer_size_i (buffer_size_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  rdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .has_digit_o  (has_digit_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

### rtl/rdc_checker.sv
// port-level checks for the radix digit converter, bound to the top level
`include "radix_digit_converter_defines.svh"

module rdc_checker import rdc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [CHAR_W-1:0]      digit_char_o,
  input logic                   has_digit_o,
  input logic [1:0]             status_o,
  input logic                   last_o
);

  // a stalled result holds
  `RDC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digit_char_o) && $stable(last_o) && $stable(status_o), "result changed while stalled")

  // digit results carry success and an ascii digit
  `RDC_ASSERT_NOW(a_digit_ok, out_valid_o && has_digit_o, status_o == STATUS_OK && digit_char_o >= ASCII_ZERO && digit_char_o <= ASCII_MAX, "bad digit result")

  // error results are single, flagged last and carry no character
  `RDC_ASSERT_NOW(a_error_form, out_valid_o && !has_digit_o, last_o && digit_char_o == '0 && (status_o == STATUS_BAD_BASE || status_o == STATUS_OVERFLOW), "bad error result")

  // success status only ever comes with a digit
  `RDC_ASSERT_NOW(a_ok_has_digit, out_valid_o && status_o == STATUS_OK, has_digit_o, "success without digit")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

### tb/radix_digit_converter_tb.sv
// self-checking testbench for radix_digit_converter: directed and random conversions
module radix_digit_converter_tb;
  import rdc_pkg::*;

  class conversion_scoreboard;
    typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              has_digit;
      status_e           status;
      logic              last;
    } digit_result_t;

    digit_result_t                due_digits[$];
    bit [NUMBER_BITS-1:0]         remaining_value;
    bit [DIGIT_W-1:0]             digit_store[NUMBER_BITS];
    int unsigned                  digit_count;
    int unsigned                  errors;
    int unsigned                  requests;
    int unsigned                  digits_checked;
    int unsigned                  bad_base_seen;
    int unsigned                  overflow_seen;

    function int unsigned outstanding();
      return due_digits.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    // work out the digit sequence for one accepted request
    function void note_request(logic [NUMBER_BITS-1:0] number, logic [BASE_W-1:0] base,
                               logic [BUFSZ_W-1:0] buffer_size);
      digit_result_t r;
      int unsigned   radix;
      requests++;
      if (base < BASE_MIN || base > BASE_MAX) begin
        r = '{digit_char: '0, has_digit: 1'b0, status: STATUS_BAD_BASE, last: 1'b1};
        due_digits.push_back(r);
        bad_base_seen++;
        return;
      end
      radix = base;
      remaining_value = number;
      digit_count = 0;
      do begin
        digit_store[digit_count] = DIGIT_W'(remaining_value % radix);
        remaining_value = remaining_value / radix;
        digit_count++;
      end while (remaining_value != 0 && digit_count < NUMBER_BITS);
      if (digit_count + 1 > buffer_size) begin
        r = '{digit_char: '0, has_digit: 1'b0, status: STATUS_OVERFLOW, last: 1'b1};
        due_digits.push_back(r);
        overflow_seen++;
        return;
      end
      // most significant digit first
      for (int k = int'(digit_count) - 1; k >= 0; k--) begin
        r.digit_char = ASCII_ZERO + CHAR_W'(digit_store[k]);
        r.has_digit  = 1'b1;
        r.status     = STATUS_OK;
        r.last       = (k == 0);
        due_digits.push_back(r);
      end
    endfunction

    task check_digit(logic [CHAR_W-1:0] digit_char, logic has_digit,
                     logic [1:0] status, logic last);
      digit_result_t want;
      if (due_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected result char %0d has %0b status %0d last %0b",
                                  digit_char, has_digit, status, last));
        return;
      end
      want = due_digits.pop_front();
      digits_checked++;
      if (digit_char !== want.digit_char)
        report_mismatch($sformatf("digit_char %0d, expected %0d", digit_char, want.digit_char));
      if (has_digit !== want.has_digit)
        report_mismatch($sformatf("has_digit %0b, expected %0b", has_digit, want.has_digit));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [NUMBER_BITS-1:0] number_i = '0;
  logic [BASE_W-1:0]      base_i = '0;
  logic [BUFSZ_W-1:0]     buffer_size_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CHAR_W-1:0]      digit_char_o;
  logic                   has_digit_o;
  logic [1:0]             status_o;
  logic                   last_o;

  conversion_scoreboard sb;
  bit                   calm = 1'b0;

  radix_digit_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .number_i      (number_i),
    .base_i        (base_i),
    .buffer_size_i (buffer_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_char_o  (digit_char_o),
    .has_digit_o   (has_digit_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // called and returns at a falling edge
  task automatic send_request(logic [NUMBER_BITS-1:0] number, logic [BASE_W-1:0] base,
                              logic [BUFSZ_W-1:0] buffer_size);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    number_i      <= number;
    base_i        <= base;
    buffer_size_i <= buffer_size;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(number, base, buffer_size);
    @(negedge clk_i);
  endtask

  // output side back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_digit(digit_char_o, has_digit_o, status_o, last_o);
  end

  initial begin
    logic [NUMBER_BITS-1:0] number;
    logic [BASE_W-1:0]      base;
    logic [BUFSZ_W-1:0]     buffer_size;
    logic [NUMBER_BITS-1:0] quotient;
    int unsigned            width;
    int unsigned            need;

    sb = new();
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_request(32'd0, BASE_2, 8'd2);
    send_request(32'd0, BASE_3, 8'd1);
    send_request(32'd0, BASE_5, 8'd0);
    send_request(32'hFFFF_FFFF, BASE_2, 8'd33);
    send_request(32'hFFFF_FFFF, BASE_2, 8'd32);
    send_request(32'h8000_0000, BASE_2, 8'd255);
    send_request(32'hFFFF_FFFF, BASE_3, 8'd255);
    send_request(32'hFFFF_FFFF, BASE_4, 8'd17);
    send_request(32'hFFFF_FFFF, BASE_5, 8'd15);
    send_request(32'hFFFF_FFFF, BASE_5, 8'd14);
    send_request(32'd1234, 3'd0, 8'd255);
    send_request(32'd1, 3'd1, 8'd2);
    send_request(32'hFFFF_FFFF, 3'd6, 8'd0);
    send_request(32'd7, 3'd7, 8'd255);
    send_request(32'd1, BASE_2, 8'd2);
    send_request(32'd4, BASE_4, 8'd3);
    send_request(32'd24, BASE_5, 8'd255);
    send_request(32'd26, BASE_3, 8'd4);
    send_request(32'h1234_5678, BASE_3, 8'd0);
    send_request(32'h5555_5555, BASE_4, 8'd16);
    send_request(32'hAAAA_AAAA, BASE_2, 8'd255);

    // random conversions, the last stretch without idling
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 340);
      width = $urandom_range(0, 32);
      number = (width == 32) ? $urandom : ($urandom & ((32'd1 << width) - 1));
      if ($urandom_range(0, 19) == 0) number = 32'hFFFF_FFFF;
      if ($urandom_range(0, 9) == 0) begin
        base = BASE_W'($urandom_range(0, 7));
        buffer_size = BUFSZ_W'($urandom_range(0, 255));
      end else begin
        base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
        need = 1;
        quotient = number / base;
        while (quotient != 0) begin
          need++;
          quotient = quotient / base;
        end
        case ($urandom_range(0, 5))
          0:       buffer_size = BUFSZ_W'($urandom_range(0, 255));
          1:       buffer_size = BUFSZ_W'(need);
          2:       buffer_size = BUFSZ_W'(need + 1);
          default: buffer_size = BUFSZ_W'(need + 1 + $urandom_range(0, 40));
        endcase
      end
      send_request(number, base, buffer_size);
    end
    in_valid_i <= 1'b0;

    while (sb.outstanding() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("%0d conversions sent, %0d results checked", sb.requests, sb.digits_checked);
    $display("%0d invalid base and %0d overflow results predicted",
             sb.bad_base_seen, sb.overflow_seen);
    if (sb.errors == 0) begin
      $display("radix_digit_converter_tb OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("radix_digit_converter_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("radix_digit_converter_tb NOT OK");
    $finish;
  end

endmodule
